// ===== design/gtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared sizes, codes and types of the Gouraud triangle rasterizer.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int WIDTH       = 64;
  localparam int HEIGHT      = 64;
  localparam int T_FRAC_BITS = 16;

  localparam int FB_DEPTH = WIDTH * HEIGHT;
  localparam int FB_AW    = $clog2(FB_DEPTH);

  localparam int COORD_W = 11;
  localparam int CH_W    = 8;
  localparam int CH_N    = 3;
  localparam int RGB_W   = CH_N * CH_W;
  localparam int OP_W    = 2;

  // fraction t in [0, 1] needs one bit above the fraction
  localparam int T_W    = T_FRAC_BITS + 1;
  localparam int T_ONE  = 1 << T_FRAC_BITS;
  localparam int T_HALF = 1 << (T_FRAC_BITS - 1);

  // blend operands hold a coordinate or a channel plus a sign bit
  localparam int OPER_W = COORD_W + 1;
  localparam int PROD_W = OPER_W + T_W + 1;

  // divider: dividend is num << T_FRAC_BITS
  localparam int DIV_W  = COORD_W + T_FRAC_BITS;
  localparam int DIV_CW = $clog2(DIV_W + 1);

  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_READ,
    K_FLAT,
    K_SPLIT
  } kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [0:CH_N-1][CH_W-1:0] c;   // c[0] red, c[2] blue
  } vertex_t;

  // FLAT:  va left, vb right, vc apex
  // SPLIT: va middle, vb and vc the ends of the long edge; vb's half is drawn before vc's
  typedef struct packed {
    kind_t   kind;
    vertex_t va;
    vertex_t vb;
    vertex_t vc;
  } cmd_t;

endpackage

// ===== design/gtr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gtr_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 4096,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/gtr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_div
// Restoring divider, one quotient bit a cycle: (num << T_FRAC_BITS) / den.
// ----------------------------------------------------------------------------
module gtr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gtr_pkg::COORD_W-1:0] num,
  input  logic [gtr_pkg::COORD_W-1:0] den,
  output logic                        busy,
  output logic                        done,
  output logic [gtr_pkg::T_W-1:0]     quot,
  output logic [gtr_pkg::COORD_W-1:0] rem
);

  logic [gtr_pkg::DIV_W-1:0]   dvd_r, dvd_nxt;
  logic [gtr_pkg::COORD_W:0]   rem_r, rem_nxt, rem_sh;
  logic [gtr_pkg::COORD_W-1:0] den_r;
  logic [gtr_pkg::DIV_CW-1:0]  cnt_r;
  logic                        busy_r, done_r;
  logic                        qbit;

  always_comb begin
    rem_sh = {rem_r[gtr_pkg::COORD_W-1:0], dvd_r[gtr_pkg::DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, den_r});
    rem_nxt = qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
    dvd_nxt = {dvd_r[gtr_pkg::DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= gtr_pkg::DIV_CW'(gtr_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - gtr_pkg::DIV_CW'(1);
        if (cnt_r == gtr_pkg::DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num, {gtr_pkg::T_FRAC_BITS{1'b0}}};
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = dvd_r[gtr_pkg::T_W-1:0];
  assign rem  = rem_r[gtr_pkg::COORD_W-1:0];

endmodule

// ===== design/gtr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_front
// Classifies an accepted item into a command: clear, read, flat or split
// triangle, vertices in walking order; degenerate draws, unused ops drop.
// ----------------------------------------------------------------------------
module gtr_front (
  input  logic                               accept,
  input  logic [gtr_pkg::OP_W-1:0]           op,
  input  logic signed [gtr_pkg::COORD_W-1:0] v1_x,
  input  logic signed [gtr_pkg::COORD_W-1:0] v1_y,
  input  logic [gtr_pkg::RGB_W-1:0]          v1_rgb,
  input  logic signed [gtr_pkg::COORD_W-1:0] v2_x,
  input  logic signed [gtr_pkg::COORD_W-1:0] v2_y,
  input  logic [gtr_pkg::RGB_W-1:0]          v2_rgb,
  input  logic signed [gtr_pkg::COORD_W-1:0] v3_x,
  input  logic signed [gtr_pkg::COORD_W-1:0] v3_y,
  input  logic [gtr_pkg::RGB_W-1:0]          v3_rgb,
  output logic                               cmd_valid,
  output gtr_pkg::cmd_t                      cmd
);

  function automatic logic between(gtr_pkg::vertex_t v, gtr_pkg::vertex_t a,
                                   gtr_pkg::vertex_t b);
    return (v.y < a.y && v.y > b.y) || (v.y > a.y && v.y < b.y);
  endfunction

  // flat edge p-q is the base, lower column left, p first on ties
  function automatic gtr_pkg::cmd_t mk_flat(gtr_pkg::vertex_t p, gtr_pkg::vertex_t q,
                                            gtr_pkg::vertex_t ap);
    gtr_pkg::cmd_t c;
    c.kind = gtr_pkg::K_FLAT;
    if (q.x < p.x) begin
      c.va = q;
      c.vb = p;
    end else begin
      c.va = p;
      c.vb = q;
    end
    c.vc = ap;
    return c;
  endfunction

  gtr_pkg::vertex_t va, vb, vc;
  logic ab, ac, bc, keep;

  always_comb begin
    va.x = v1_x; va.y = v1_y; va.c = v1_rgb;
    vb.x = v2_x; vb.y = v2_y; vb.c = v2_rgb;
    vc.x = v3_x; vc.y = v3_y; vc.c = v3_rgb;
    ab = (va.y == vb.y);
    ac = (va.y == vc.y);
    bc = (vb.y == vc.y);

    keep     = 1'b0;
    cmd.kind = gtr_pkg::K_CLEAR;
    cmd.va   = va;
    cmd.vb   = vb;
    cmd.vc   = vc;
    case (op)
      gtr_pkg::OP_CLEAR: begin
        keep = 1'b1;
      end
      gtr_pkg::OP_READ: begin
        keep     = 1'b1;
        cmd.kind = gtr_pkg::K_READ;
      end
      gtr_pkg::OP_DRAW: begin
        keep = 1'b1;
        if (ab && bc) begin
          keep = 1'b0;
        end else if (ab) begin
          cmd = mk_flat(va, vb, vc);
        end else if (ac) begin
          cmd = mk_flat(va, vc, vb);
        end else if (bc) begin
          cmd = mk_flat(vb, vc, va);
        end else begin
          cmd.kind = gtr_pkg::K_SPLIT;
          if (between(va, vb, vc)) begin
            cmd.va = va; cmd.vb = vb; cmd.vc = vc;
          end else if (between(vb, va, vc)) begin
            cmd.va = vb; cmd.vb = va; cmd.vc = vc;
          end else begin
            cmd.va = vc; cmd.vb = va; cmd.vc = vb;
          end
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    cmd_valid = accept && keep;
  end

endmodule

// ===== design/gtr_cmdq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module gtr_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  gtr_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd,
  output logic          valid,
  output gtr_pkg::cmd_t rdata
);

  gtr_pkg::cmd_t             mem_r [gtr_pkg::CQ_DEPTH];
  logic [gtr_pkg::CQ_AW-1:0] wp_r, rp_r;
  logic [gtr_pkg::CQ_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + gtr_pkg::CQ_AW'(1);
      end
      if (rd) begin
        rp_r <= rp_r + gtr_pkg::CQ_AW'(1);
      end
      cnt_r <= cnt_r + (gtr_pkg::CQ_AW + 1)'(wr) - (gtr_pkg::CQ_AW + 1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign full  = (cnt_r == (gtr_pkg::CQ_AW + 1)'(gtr_pkg::CQ_DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rp_r];

endmodule

// ===== design/gtr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_back
// Command sequencer: clear sweep, pixel read, and the triangle walk with a
// shared blend multiplier and a shared serial divider.
// ----------------------------------------------------------------------------
module gtr_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  gtr_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  output logic                      init_busy,
  input  logic                      out_pop,
  output logic                      out_valid,
  output logic [gtr_pkg::RGB_W-1:0] out_rgb
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_RD_OUT, S_SP_DIV, S_SP_WAIT, S_SP_BL, S_SP_SEL,
    S_HALF, S_HALF_WAIT, S_ROW_BL, S_SPAN, S_SPAN_WAIT, S_PIX_BL, S_PIX_WR,
    S_ROW_NEXT
  } state_t;

  localparam logic [3:0] BL_SP_N  = 4'd4;
  localparam logic [3:0] BL_ROW_N = 4'd8;
  localparam logic [3:0] BL_PIX_N = 4'd3;

  localparam int CW = gtr_pkg::COORD_W;
  localparam int OW = gtr_pkg::OPER_W;

  function automatic logic [CW-1:0] absdiff(logic signed [CW-1:0] a,
                                            logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    d = (CW + 1)'(a) - (CW + 1)'(b);
    return d[CW] ? CW'(-d) : CW'(d);
  endfunction

  function automatic logic in_fb(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    return !x[CW-1] && !y[CW-1] &&
           ({1'b0, x} < (CW + 1)'(gtr_pkg::WIDTH)) &&
           ({1'b0, y} < (CW + 1)'(gtr_pkg::HEIGHT));
  endfunction

  function automatic logic [gtr_pkg::FB_AW-1:0] fb_addr(logic signed [CW-1:0] x,
                                                        logic signed [CW-1:0] y);
    return gtr_pkg::FB_AW'(y[CW-2:0]) * gtr_pkg::FB_AW'(gtr_pkg::WIDTH) +
           gtr_pkg::FB_AW'(x[CW-2:0]);
  endfunction

  function automatic logic signed [OW-1:0] ext_x(logic signed [CW-1:0] x);
    return OW'(x);
  endfunction

  function automatic logic signed [OW-1:0] ext_c(logic [gtr_pkg::CH_W-1:0] c);
    return $signed(OW'(c));
  endfunction

  state_t state_r;
  gtr_pkg::cmd_t cmd_r;
  logic init_r;
  logic [gtr_pkg::FB_AW-1:0] clr_addr_r;
  logic [gtr_pkg::RGB_W-1:0] clr_rgb_r;
  logic out_valid_r, rd_zero_r;
  logic [gtr_pkg::RGB_W-1:0] out_rgb_r;

  gtr_pkg::vertex_t l_r, r_r, ap_r, ap2_r, h_r;
  logic second_r;
  logic [gtr_pkg::T_W-1:0] t_spl_r;

  // row walk
  logic [gtr_pkg::T_W-1:0] q_row_r, t_row_r;
  logic [CW-1:0] r_row_r, den_row_r, rem_row_r, rows_left_r;
  logic signed [CW-1:0] row_y_r;
  logic row_dn_r;
  logic signed [CW-1:0] lx_r, rx_r;
  logic [0:gtr_pkg::CH_N-1][gtr_pkg::CH_W-1:0] lc_r, rc_r, pc_r;

  // span walk
  logic [gtr_pkg::T_W-1:0] q_sp_r, t_sp_r;
  logic [CW-1:0] r_sp_r, den_sp_r, rem_sp_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW:0] span_len;

  logic [3:0] bl_idx_r;

  // blend: a + floor(((b - a) * t + half) / one)
  logic signed [OW-1:0] bl_a, bl_b, bl_a_r, bl_res;
  logic [gtr_pkg::T_W-1:0] bl_t;
  logic signed [gtr_pkg::PROD_W-1:0] bl_prod_r, bl_sum;

  // incremental fraction steps
  logic [CW:0] row_rem_sum, sp_rem_sum;
  logic [gtr_pkg::T_W-1:0] row_t_nxt, sp_t_nxt;
  logic [CW-1:0] row_rem_nxt, sp_rem_nxt;

  logic div_start, div_busy, div_done;
  logic [CW-1:0] div_num, div_den, div_rem;
  logic [gtr_pkg::T_W-1:0] div_quot;

  logic ram_we, ram_re, load_out;
  logic [gtr_pkg::FB_AW-1:0] ram_waddr, ram_raddr;
  logic [gtr_pkg::RGB_W-1:0] ram_wdata, ram_rdata;

  assign span_len = (CW + 1)'(rx_r) - (CW + 1)'(lx_r);

  always_comb begin
    bl_a = '0;
    bl_b = '0;
    bl_t = t_row_r;
    case (state_r)
      S_SP_BL: begin
        bl_t = t_spl_r;
        case (bl_idx_r)
          4'd0: begin bl_a = ext_x(cmd_r.vb.x); bl_b = ext_x(cmd_r.vc.x); end
          4'd1: begin bl_a = ext_c(cmd_r.vb.c[0]); bl_b = ext_c(cmd_r.vc.c[0]); end
          4'd2: begin bl_a = ext_c(cmd_r.vb.c[1]); bl_b = ext_c(cmd_r.vc.c[1]); end
          4'd3: begin bl_a = ext_c(cmd_r.vb.c[2]); bl_b = ext_c(cmd_r.vc.c[2]); end
          default: begin end
        endcase
      end
      S_ROW_BL: begin
        case (bl_idx_r)
          4'd0: begin bl_a = ext_x(l_r.x); bl_b = ext_x(ap_r.x); end
          4'd1: begin bl_a = ext_x(r_r.x); bl_b = ext_x(ap_r.x); end
          4'd2: begin bl_a = ext_c(l_r.c[0]); bl_b = ext_c(ap_r.c[0]); end
          4'd3: begin bl_a = ext_c(l_r.c[1]); bl_b = ext_c(ap_r.c[1]); end
          4'd4: begin bl_a = ext_c(l_r.c[2]); bl_b = ext_c(ap_r.c[2]); end
          4'd5: begin bl_a = ext_c(r_r.c[0]); bl_b = ext_c(ap_r.c[0]); end
          4'd6: begin bl_a = ext_c(r_r.c[1]); bl_b = ext_c(ap_r.c[1]); end
          4'd7: begin bl_a = ext_c(r_r.c[2]); bl_b = ext_c(ap_r.c[2]); end
          default: begin end
        endcase
      end
      S_PIX_BL: begin
        bl_t = t_sp_r;
        case (bl_idx_r)
          4'd0: begin bl_a = ext_c(lc_r[0]); bl_b = ext_c(rc_r[0]); end
          4'd1: begin bl_a = ext_c(lc_r[1]); bl_b = ext_c(rc_r[1]); end
          4'd2: begin bl_a = ext_c(lc_r[2]); bl_b = ext_c(rc_r[2]); end
          default: begin end
        endcase
      end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    bl_a_r    <= bl_a;
    bl_prod_r <= gtr_pkg::PROD_W'(bl_b - bl_a) * $signed({1'b0, bl_t});
  end

  always_comb begin
    bl_sum = bl_prod_r + gtr_pkg::PROD_W'(gtr_pkg::T_HALF);
    bl_res = bl_a_r + OW'(bl_sum >>> gtr_pkg::T_FRAC_BITS);
  end

  always_comb begin
    row_rem_sum = {1'b0, rem_row_r} + {1'b0, r_row_r};
    if (row_rem_sum >= {1'b0, den_row_r}) begin
      row_rem_nxt = CW'(row_rem_sum - {1'b0, den_row_r});
      row_t_nxt   = t_row_r + q_row_r + gtr_pkg::T_W'(1);
    end else begin
      row_rem_nxt = row_rem_sum[CW-1:0];
      row_t_nxt   = t_row_r + q_row_r;
    end
    sp_rem_sum = {1'b0, rem_sp_r} + {1'b0, r_sp_r};
    if (sp_rem_sum >= {1'b0, den_sp_r}) begin
      sp_rem_nxt = CW'(sp_rem_sum - {1'b0, den_sp_r});
      sp_t_nxt   = t_sp_r + q_sp_r + gtr_pkg::T_W'(1);
    end else begin
      sp_rem_nxt = sp_rem_sum[CW-1:0];
      sp_t_nxt   = t_sp_r + q_sp_r;
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      S_SP_DIV: begin
        div_start = 1'b1;
        div_num   = absdiff(cmd_r.va.y, cmd_r.vb.y);
        div_den   = absdiff(cmd_r.vb.y, cmd_r.vc.y);
      end
      S_HALF: begin
        div_start = 1'b1;
        div_num   = CW'(1);
        div_den   = absdiff(ap_r.y, l_r.y);
      end
      S_SPAN: begin
        div_start = !span_len[CW] && (span_len != '0);
        div_num   = CW'(1);
        div_den   = span_len[CW-1:0];
      end
      default: begin end
    endcase
  end

  always_comb begin
    cmd_pop   = (state_r == S_IDLE) && cmd_valid;
    ram_we    = (state_r == S_CLR) || ((state_r == S_PIX_WR) && in_fb(x_r, row_y_r));
    ram_waddr = (state_r == S_CLR) ? clr_addr_r : fb_addr(x_r, row_y_r);
    ram_wdata = (state_r == S_CLR) ? clr_rgb_r : pc_r;
    ram_re    = (state_r == S_RD);
    ram_raddr = fb_addr(cmd_r.va.x, cmd_r.va.y);
    load_out  = (state_r == S_RD_OUT) && (!out_valid_r || out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      init_r      <= 1'b1;
      clr_addr_r  <= '0;
      clr_rgb_r   <= '0;
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
      bl_idx_r    <= '0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_rgb_r   <= rd_zero_r ? '0 : ram_rdata;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + gtr_pkg::FB_AW'(1);
          if (clr_addr_r == gtr_pkg::FB_AW'(gtr_pkg::FB_DEPTH - 1)) begin
            init_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            case (cmd.kind)
              gtr_pkg::K_CLEAR: begin
                clr_rgb_r  <= cmd.va.c;
                clr_addr_r <= '0;
                state_r    <= S_CLR;
              end
              gtr_pkg::K_READ: begin
                state_r <= S_RD;
              end
              gtr_pkg::K_FLAT: begin
                l_r      <= cmd.va;
                r_r      <= cmd.vb;
                ap_r     <= cmd.vc;
                second_r <= 1'b0;
                state_r  <= S_HALF;
              end
              default: begin
                state_r <= S_SP_DIV;
              end
            endcase
          end
        end
        S_RD: begin
          rd_zero_r <= !in_fb(cmd_r.va.x, cmd_r.va.y);
          state_r   <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        S_SP_DIV: begin
          state_r <= S_SP_WAIT;
        end
        S_SP_WAIT: begin
          if (div_done) begin
            t_spl_r  <= div_quot;
            h_r.y    <= cmd_r.va.y;
            bl_idx_r <= '0;
            state_r  <= S_SP_BL;
          end
        end
        S_SP_BL: begin
          bl_idx_r <= bl_idx_r + 4'd1;
          case (bl_idx_r)
            4'd1: h_r.x    <= bl_res[CW-1:0];
            4'd2: h_r.c[0] <= bl_res[gtr_pkg::CH_W-1:0];
            4'd3: h_r.c[1] <= bl_res[gtr_pkg::CH_W-1:0];
            4'd4: h_r.c[2] <= bl_res[gtr_pkg::CH_W-1:0];
            default: begin end
          endcase
          if (bl_idx_r == BL_SP_N) begin
            state_r <= S_SP_SEL;
          end
        end
        S_SP_SEL: begin
          // middle vertex and split point form the base; split point left on ties
          if (cmd_r.va.x < h_r.x) begin
            l_r <= cmd_r.va;
            r_r <= h_r;
          end else begin
            l_r <= h_r;
            r_r <= cmd_r.va;
          end
          ap_r     <= cmd_r.vb;
          ap2_r    <= cmd_r.vc;
          second_r <= 1'b1;
          state_r  <= S_HALF;
        end
        S_HALF: begin
          row_y_r     <= l_r.y;
          rows_left_r <= absdiff(ap_r.y, l_r.y);
          den_row_r   <= absdiff(ap_r.y, l_r.y);
          row_dn_r    <= (ap_r.y < l_r.y);
          t_row_r     <= '0;
          rem_row_r   <= '0;
          state_r     <= S_HALF_WAIT;
        end
        S_HALF_WAIT: begin
          if (div_done) begin
            q_row_r  <= div_quot;
            r_row_r  <= div_rem;
            bl_idx_r <= '0;
            state_r  <= S_ROW_BL;
          end
        end
        S_ROW_BL: begin
          bl_idx_r <= bl_idx_r + 4'd1;
          case (bl_idx_r)
            4'd1: lx_r     <= bl_res[CW-1:0];
            4'd2: rx_r     <= bl_res[CW-1:0];
            4'd3: lc_r[0]  <= bl_res[gtr_pkg::CH_W-1:0];
            4'd4: lc_r[1]  <= bl_res[gtr_pkg::CH_W-1:0];
            4'd5: lc_r[2]  <= bl_res[gtr_pkg::CH_W-1:0];
            4'd6: rc_r[0]  <= bl_res[gtr_pkg::CH_W-1:0];
            4'd7: rc_r[1]  <= bl_res[gtr_pkg::CH_W-1:0];
            4'd8: rc_r[2]  <= bl_res[gtr_pkg::CH_W-1:0];
            default: begin end
          endcase
          if (bl_idx_r == BL_ROW_N) begin
            state_r <= S_SPAN;
          end
        end
        S_SPAN: begin
          x_r      <= lx_r;
          t_sp_r   <= '0;
          rem_sp_r <= '0;
          den_sp_r <= span_len[CW-1:0];
          bl_idx_r <= '0;
          if (span_len[CW]) begin
            state_r <= S_ROW_NEXT;
          end else if (span_len == '0) begin
            state_r <= S_PIX_BL;
          end else begin
            state_r <= S_SPAN_WAIT;
          end
        end
        S_SPAN_WAIT: begin
          if (div_done) begin
            q_sp_r  <= div_quot;
            r_sp_r  <= div_rem;
            state_r <= S_PIX_BL;
          end
        end
        S_PIX_BL: begin
          bl_idx_r <= bl_idx_r + 4'd1;
          case (bl_idx_r)
            4'd1: pc_r[0] <= bl_res[gtr_pkg::CH_W-1:0];
            4'd2: pc_r[1] <= bl_res[gtr_pkg::CH_W-1:0];
            4'd3: pc_r[2] <= bl_res[gtr_pkg::CH_W-1:0];
            default: begin end
          endcase
          if (bl_idx_r == BL_PIX_N) begin
            state_r <= S_PIX_WR;
          end
        end
        S_PIX_WR: begin
          bl_idx_r <= '0;
          if (x_r == rx_r) begin
            state_r <= S_ROW_NEXT;
          end else begin
            x_r      <= x_r + CW'(1);
            t_sp_r   <= sp_t_nxt;
            rem_sp_r <= sp_rem_nxt;
            state_r  <= S_PIX_BL;
          end
        end
        S_ROW_NEXT: begin
          bl_idx_r <= '0;
          if (rows_left_r == '0) begin
            if (second_r) begin
              ap_r     <= ap2_r;
              second_r <= 1'b0;
              state_r  <= S_HALF;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            rows_left_r <= rows_left_r - CW'(1);
            row_y_r     <= row_dn_r ? (row_y_r - CW'(1)) : (row_y_r + CW'(1));
            t_row_r     <= row_t_nxt;
            rem_row_r   <= row_rem_nxt;
            state_r     <= S_ROW_BL;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  gtr_ram #(
    .DATA_W(gtr_pkg::RGB_W),
    .DEPTH (gtr_pkg::FB_DEPTH)
  ) u_fb (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  gtr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_rgb   = out_rgb_r;

`ifndef NO_ASSERTIONS
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLR || state_r == S_PIX_WR))
    else $error("frame buffer written outside clear or pixel write");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");
  a_row_t: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW_BL) |-> (t_row_r <= gtr_pkg::T_W'(gtr_pkg::T_ONE)))
    else $error("row fraction above one");
  a_pix_x: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PIX_WR) |-> (x_r >= lx_r && x_r <= rx_r &&
                               t_sp_r <= gtr_pkg::T_W'(gtr_pkg::T_ONE)))
    else $error("pixel outside its span");
`endif

endmodule

// ===== design/gouraud_triangle_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gouraud_triangle_rasterizer
// Scanline Gouraud triangle fill over an on-chip RGB frame buffer.
// ----------------------------------------------------------------------------
// Usage: after reset the frame buffer is swept to zero, one pixel a cycle;
// in_full stays high throughout. Items then enter a two-deep command
// queue and are carried out in order. A clear (op 0) sweeps the whole
// buffer, one pixel a cycle. A read (op 2) yields one item on the out_
// side; it can wait there while later items go on. A triangle (op 1) is
// drawn per half: a setup division (serial divider, one bit a cycle, 27
// bits), then per row the edge blending plus a span division (none for a
// one-pixel span), and per pixel the colour blending, bound by the single
// shared blend multiplier that serves three channels in turn. A split
// triangle first finds its split point with the divider and the blend
// multiplier. Zero-height triangles and the unused op are dropped at the
// front and cost no back-end time.
// ----------------------------------------------------------------------------
module gouraud_triangle_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [gtr_pkg::OP_W-1:0]           in_op,
  input  logic signed [gtr_pkg::COORD_W-1:0] in_v1_x,
  input  logic signed [gtr_pkg::COORD_W-1:0] in_v1_y,
  input  logic [gtr_pkg::RGB_W-1:0]          in_v1_rgb,
  input  logic signed [gtr_pkg::COORD_W-1:0] in_v2_x,
  input  logic signed [gtr_pkg::COORD_W-1:0] in_v2_y,
  input  logic [gtr_pkg::RGB_W-1:0]          in_v2_rgb,
  input  logic signed [gtr_pkg::COORD_W-1:0] in_v3_x,
  input  logic signed [gtr_pkg::COORD_W-1:0] in_v3_y,
  input  logic [gtr_pkg::RGB_W-1:0]          in_v3_rgb,
  // result items
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [gtr_pkg::RGB_W-1:0]          out_read_rgb
);

  logic          accept;
  logic          fr_valid;
  gtr_pkg::cmd_t fr_cmd;
  logic          q_full, q_valid, q_pop;
  gtr_pkg::cmd_t q_cmd;
  logic          init_busy;
  logic          out_valid;

  // items are held off while the queue is full or the reset sweep runs
  assign in_full = q_full || init_busy;
  assign accept  = in_push && !in_full;

  // front: classification, vertex ordering, degenerate and unused-op drop
  gtr_front u_front (
    .accept   (accept),
    .op       (in_op),
    .v1_x     (in_v1_x),
    .v1_y     (in_v1_y),
    .v1_rgb   (in_v1_rgb),
    .v2_x     (in_v2_x),
    .v2_y     (in_v2_y),
    .v2_rgb   (in_v2_rgb),
    .v3_x     (in_v3_x),
    .v3_y     (in_v3_y),
    .v3_rgb   (in_v3_rgb),
    .cmd_valid(fr_valid),
    .cmd      (fr_cmd)
  );

  // decoupling queue
  gtr_cmdq u_cmdq (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (fr_valid),
    .wdata(fr_cmd),
    .full (q_full),
    .rd   (q_pop),
    .valid(q_valid),
    .rdata(q_cmd)
  );

  // back: frame buffer, sequencer, result register
  gtr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(q_valid),
    .cmd      (q_cmd),
    .cmd_pop  (q_pop),
    .init_busy(init_busy),
    .out_pop  (out_pop),
    .out_valid(out_valid),
    .out_rgb  (out_read_rgb)
  );

  assign out_empty = !out_valid;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gouraud triangle rasterizer.
// ----------------------------------------------------------------------------
// Items (clears, triangles, pixel reads, the unused op) are queued by an
// initial block. A clocked driver feeds them in through the push/full
// handshake, with random gaps between items. A clocked monitor pops read
// results with random stalls. A bench-side copy of the frame buffer is
// redrawn for each accepted clear or triangle. The expected colour of each
// read is queued and compared with the popped item.
// ----------------------------------------------------------------------------
module tb_top;
  import gtr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] ax, ay;
    logic [RGB_W-1:0]          argb;
    logic signed [COORD_W-1:0] bx, by;
    logic [RGB_W-1:0]          brgb;
    logic signed [COORD_W-1:0] cx, cy;
    logic [RGB_W-1:0]          crgb;
  } item_t;

  // one vertex as plain integers
  typedef struct packed {
    int x;
    int y;
    int r;
    int g;
    int b;
  } pt_t;

  logic clk, rst_n;
  logic in_push, in_full, out_empty, out_pop;
  logic [OP_W-1:0] in_op;
  logic signed [COORD_W-1:0] in_v1_x, in_v1_y, in_v2_x, in_v2_y, in_v3_x, in_v3_y;
  logic [RGB_W-1:0] in_v1_rgb, in_v2_rgb, in_v3_rgb, out_read_rgb;

  item_t            pend_q[$];
  logic [RGB_W-1:0] pixel_expect_q[$];
  logic [RGB_W-1:0] shadow_fb [0:FB_DEPTH-1];

  int n_fail, n_reads_checked, n_draws, n_clears, n_other;
  int send_gap, pop_stall;
  bit calm_in, calm_out;   // stretches with no idling

  gouraud_triangle_rasterizer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_op       (in_op),
    .in_v1_x     (in_v1_x),
    .in_v1_y     (in_v1_y),
    .in_v1_rgb   (in_v1_rgb),
    .in_v2_x     (in_v2_x),
    .in_v2_y     (in_v2_y),
    .in_v2_rgb   (in_v2_rgb),
    .in_v3_x     (in_v3_x),
    .in_v3_y     (in_v3_y),
    .in_v3_rgb   (in_v3_rgb),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_read_rgb(out_read_rgb)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- queues
  task automatic queue_item(item_t it);
    pend_q = {pend_q, it};
  endtask

  task automatic expect_pixel(logic [RGB_W-1:0] v);
    pixel_expect_q = {pixel_expect_q, v};
  endtask

  // ---------------------------------------------------------------- predictor
  // fraction num/den in T_FRAC_BITS, zero for empty ranges
  function automatic longint frac_t(int num, int den);
    if (den <= 0 || num <= 0) return 0;
    return (longint'(num) << T_FRAC_BITS) / longint'(den);
  endfunction

  // a..b at t, rounded half up (arithmetic shift gives the floor)
  function automatic int lerp(int a, int b, longint t);
    longint v;
    v = longint'(a) * (longint'(T_ONE) - t) + longint'(b) * t + longint'(T_HALF);
    return int'(v >>> T_FRAC_BITS);
  endfunction

  function automatic pt_t lerp_pt(pt_t a, pt_t b, longint t);
    pt_t p;
    p.x = lerp(a.x, b.x, t);
    p.y = lerp(a.y, b.y, t);
    p.r = lerp(a.r, b.r, t);
    p.g = lerp(a.g, b.g, t);
    p.b = lerp(a.b, b.b, t);
    return p;
  endfunction

  task automatic plot(int x, int y, int r, int g, int b);
    if (x < 0 || x >= WIDTH || y < 0 || y >= HEIGHT) return;
    shadow_fb[y * WIDTH + x] = {r[7:0], g[7:0], b[7:0]};
  endtask

  task automatic fill_span(int y, pt_t lp, pt_t rp);
    int len;
    longint t;
    len = rp.x - lp.x;
    for (int x = lp.x; x <= rp.x; x++) begin
      t = frac_t(x - lp.x, len);
      plot(x, y, lerp(lp.r, rp.r, t), lerp(lp.g, rp.g, t), lerp(lp.b, rp.b, t));
    end
  endtask

  // base row from l to r, walked towards the apex row inclusive
  task automatic fill_half(pt_t l, pt_t r, pt_t apex);
    int step, height;
    longint t;
    if (apex.y == l.y) return;
    step   = (apex.y > l.y) ? 1 : -1;
    height = (apex.y > l.y) ? apex.y - l.y : l.y - apex.y;
    for (int i = 0; i <= height; i++) begin
      t = frac_t(i, height);
      fill_span(l.y + step * i, lerp_pt(l, apex, t), lerp_pt(r, apex, t));
    end
  endtask

  task automatic fill_flat(pt_t p, pt_t q, pt_t apex);
    if (q.x < p.x) fill_half(q, p, apex);
    else           fill_half(p, q, apex);
  endtask

  function automatic bit strictly_between(pt_t v, pt_t a, pt_t b);
    return (v.y < a.y && v.y > b.y) || (v.y > a.y && v.y < b.y);
  endfunction

  task automatic fill_triangle(pt_t a, pt_t b, pt_t c);
    pt_t m, e1, e2, h;
    int num, den;
    if (a.y == b.y && b.y == c.y) return;   // zero height
    if (a.y == b.y) begin fill_flat(a, b, c); return; end
    if (a.y == c.y) begin fill_flat(a, c, b); return; end
    if (b.y == c.y) begin fill_flat(b, c, a); return; end
    if (strictly_between(a, b, c)) begin
      m = a; e1 = b; e2 = c;
    end else if (strictly_between(b, a, c)) begin
      m = b; e1 = a; e2 = c;
    end else begin
      m = c; e1 = a; e2 = b;
    end
    num = (m.y > e1.y) ? m.y - e1.y : e1.y - m.y;
    den = (e1.y > e2.y) ? e1.y - e2.y : e2.y - e1.y;
    h   = lerp_pt(e1, e2, frac_t(num, den));
    h.y = m.y;
    // split point is left end on ties
    if (m.x < h.x) begin
      fill_half(m, h, e1);
      fill_half(m, h, e2);
    end else begin
      fill_half(h, m, e1);
      fill_half(h, m, e2);
    end
  endtask

  function automatic pt_t to_pt(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                logic [RGB_W-1:0] rgb);
    pt_t p;
    p.x = int'(x);
    p.y = int'(y);
    p.r = int'(rgb[23:16]);
    p.g = int'(rgb[15:8]);
    p.b = int'(rgb[7:0]);
    return p;
  endfunction

  task automatic apply_item(item_t it);
    int ax, ay;
    ax = int'(it.ax);
    ay = int'(it.ay);
    case (it.op)
      OP_CLEAR: begin
        for (int i = 0; i < FB_DEPTH; i++) shadow_fb[i] = it.argb;
        n_clears++;
      end
      OP_DRAW: begin
        fill_triangle(to_pt(it.ax, it.ay, it.argb), to_pt(it.bx, it.by, it.brgb),
                      to_pt(it.cx, it.cy, it.crgb));
        n_draws++;
      end
      OP_READ: begin
        if (ax >= 0 && ax < WIDTH && ay >= 0 && ay < HEIGHT)
          expect_pixel(shadow_fb[ay * WIDTH + ax]);
        else
          expect_pixel('0);
      end
      default: n_other++;
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus
  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic item_t mk(logic [OP_W-1:0] op, int ax, int ay, int argb,
                               int bx, int by, int brgb, int cx, int cy, int crgb);
    item_t it;
    it.op = op;
    it.ax = ax[COORD_W-1:0]; it.ay = ay[COORD_W-1:0]; it.argb = argb[RGB_W-1:0];
    it.bx = bx[COORD_W-1:0]; it.by = by[COORD_W-1:0]; it.brgb = brgb[RGB_W-1:0];
    it.cx = cx[COORD_W-1:0]; it.cy = cy[COORD_W-1:0]; it.crgb = crgb[RGB_W-1:0];
    return it;
  endfunction

  // random triangle in a box; box mostly small and near the buffer
  function automatic item_t rand_tri();
    int sz, ox, oy;
    sz = ($urandom_range(0, 99) < 4) ? $urandom_range(20, 63) : $urandom_range(1, 16);
    if ($urandom_range(0, 99) < 70) begin
      ox = $urandom_range(0, 75) - 8;
      oy = $urandom_range(0, 75) - 8;
    end else begin
      ox = $urandom_range(0, 2047 - sz) - 1024;
      oy = $urandom_range(0, 2047 - sz) - 1024;
    end
    return mk(OP_DRAW,
              ox + $urandom_range(0, sz), oy + $urandom_range(0, sz), $urandom,
              ox + $urandom_range(0, sz), oy + $urandom_range(0, sz), $urandom,
              ox + $urandom_range(0, sz), oy + $urandom_range(0, sz), $urandom);
  endfunction

  function automatic item_t rand_read();
    item_t it;
    it = mk(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 99) < 15) begin
      it.ax = COORD_W'($urandom);
      it.ay = COORD_W'($urandom);
    end
    return it;
  endfunction

  initial begin
    int r;
    n_fail = 0; n_reads_checked = 0; n_draws = 0; n_clears = 0; n_other = 0;
    for (int i = 0; i < FB_DEPTH; i++) shadow_fb[i] = '0;

    // directed part
    queue_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));          // cleared at reset
    queue_item(mk(OP_CLEAR, 0, 0, 24'hFFFFFF, 0, 0, 0, 0, 0, 0));
    queue_item(mk(OP_READ, 63, 63, 0, 0, 0, 0, 0, 0, 0));
    queue_item(mk(OP_CLEAR, 0, 0, 24'h000000, 0, 0, 0, 0, 0, 0));
    // general split triangle, colours at the extremes
    queue_item(mk(OP_DRAW, 5, 2, 24'hFF0000, 30, 20, 24'h00FF00, 12, 40, 24'h0000FF));
    queue_item(mk(OP_READ, 15, 20, 0, 0, 0, 0, 0, 0, 0));
    // flat top and flat bottom, the first with its base order reversed in input
    queue_item(mk(OP_DRAW, 60, 45, 24'h123456, 40, 45, 24'hABCDEF, 50, 60, 24'hFFFFFF));
    queue_item(mk(OP_DRAW, 40, 30, 24'h00FFFF, 58, 12, 24'hFF00FF, 45, 30, 24'h808080));
    queue_item(mk(OP_READ, 50, 45, 0, 0, 0, 0, 0, 0, 0));
    // flat base with equal columns, first in input order wins
    queue_item(mk(OP_DRAW, 3, 50, 24'h111111, 3, 50, 24'hEEEEEE, 10, 58, 24'h777777));
    // zero height draws nothing
    queue_item(mk(OP_DRAW, 0, 10, 24'hFFFFFF, 63, 10, 24'hFFFFFF, 30, 10, 24'hFFFFFF));
    queue_item(mk(OP_READ, 30, 10, 0, 0, 0, 0, 0, 0, 0));
    // partly outside the buffer, and two at the coordinate extremes
    queue_item(mk(OP_DRAW, -6, -4, 24'hC0FFEE, 70, 8, 24'h0F0F0F, 2, 66, 24'hF0F0F0));
    queue_item(mk(OP_DRAW, -1024, -1024, 24'hFFFFFF, -1020, 1023 - 2047, 0,
                  -1021, -1019, 24'h5A5A5A));
    queue_item(mk(OP_DRAW, 1023, 1023, 0, 1019, 1020, 24'hFFFFFF, 1022, 1018, 24'hA5A5A5));
    queue_item(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // reads outside the buffer return zero
    queue_item(mk(OP_READ, -1, 5, 0, 0, 0, 0, 0, 0, 0));
    queue_item(mk(OP_READ, 64, 5, 0, 0, 0, 0, 0, 0, 0));
    queue_item(mk(OP_READ, 5, 64, 0, 0, 0, 0, 0, 0, 0));
    queue_item(mk(OP_READ, -1024, -1024, 0, 0, 0, 0, 0, 0, 0));
    queue_item(mk(OP_READ, 1023, 1023, 24'hFFFFFF, 0, 0, 0, 0, 0, 0));
    // unused op is ignored
    queue_item(mk(OP_UNUSED, 1, 1, 24'hFFFFFF, 2, 2, 0, 3, 3, 0));
    queue_item(mk(OP_READ, 1, 1, 0, 0, 0, 0, 0, 0, 0));

    // random part: draws and reads in about equal share, a few clears and unused ops
    for (int i = 0; i < 400; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        queue_item(mk(OP_CLEAR, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      else if (r < 5)
        queue_item(mk(OP_UNUSED, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      else if (r < 50)
        queue_item(rand_tri());
      else
        queue_item(rand_read());
    end
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push   <= 1'b0;
      in_op     <= '0;
      in_v1_x   <= '0; in_v1_y <= '0; in_v1_rgb <= '0;
      in_v2_x   <= '0; in_v2_y <= '0; in_v2_rgb <= '0;
      in_v3_x   <= '0; in_v3_y <= '0; in_v3_rgb <= '0;
      send_gap  <= 0;
      calm_in   <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        apply_item(pend_q.pop_front());
        if ($urandom_range(0, 99) < 4) calm_in <= ~calm_in;
      end
      if (in_push && in_full) begin
        // hold the offered item
      end else if (send_gap > 0) begin
        in_push  <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pend_q.size() > 0) begin
        in_push   <= 1'b1;
        in_op     <= pend_q[0].op;
        in_v1_x   <= pend_q[0].ax; in_v1_y <= pend_q[0].ay; in_v1_rgb <= pend_q[0].argb;
        in_v2_x   <= pend_q[0].bx; in_v2_y <= pend_q[0].by; in_v2_rgb <= pend_q[0].brgb;
        in_v3_x   <= pend_q[0].cx; in_v3_y <= pend_q[0].cy; in_v3_rgb <= pend_q[0].crgb;
        send_gap  <= calm_in ? 0 : pick_gap();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    logic [RGB_W-1:0] want;
    if (!rst_n) begin
      out_pop   <= 1'b0;
      pop_stall <= 0;
      calm_out  <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pixel_expect_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("ERROR: unexpected read item %06h", out_read_rgb);
        end else begin
          want = pixel_expect_q.pop_front();
          n_reads_checked++;
          if (out_read_rgb !== want) begin
            n_fail++;
            if (n_fail <= 10)
              $display("ERROR: read_rgb expected %06h got %06h", want, out_read_rgb);
          end
        end
        if ($urandom_range(0, 99) < 5) calm_out <= ~calm_out;
        pop_stall <= calm_out ? 0 : pick_gap();
        out_pop   <= 1'b0;
      end else if (pop_stall > 0) begin
        out_pop   <= 1'b0;
        pop_stall <= pop_stall - 1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- run control
  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (pend_q.size() == 0 && !in_push);
    wait (pixel_expect_q.size() == 0);
    repeat (200) @(posedge clk);   // let any trailing draw settle
    $display("Ran %0d triangles, %0d clears, %0d ignored ops; %0d pixel reads checked.",
             n_draws, n_clears, n_other, n_reads_checked);
    if (pixel_expect_q.size() != 0) n_fail++;
    if (n_fail == 0) begin
      $display("gouraud_triangle_rasterizer verification clean");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("gouraud_triangle_rasterizer verification failed");
    end
    $finish;
  end

  // generous: a limit far above the length of the whole run
  initial begin
    #200_000_000;
    $display("Timeout with %0d items pending, %0d reads outstanding",
             pend_q.size(), pixel_expect_q.size());
    $display("gouraud_triangle_rasterizer verification failed");
    $finish;
  end

endmodule
